/* sv/qcco_pkg.sv */
// shared types and constants for the quad corner reordering block
package qcco_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_CORNERS = 4;

  // corner coordinate as it arrives, and the edge vectors relative to corner a
  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;
  typedef logic signed [2*COORD_BITS+2:0] area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // sign flags of the three doubled triangle areas
  typedef struct packed {
    logic abc;
    logic acd;
    logic abd;
  } area_sign_t;

endpackage

/* sv/qcco_if.sv */
// valid/ready channels for input quads and reordered output quads
interface qcco_in_if import qcco_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by_coord;
  coord_t cx;
  coord_t cy;
  coord_t dx;
  coord_t dy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface

interface qcco_out_if import qcco_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t p0x;
  coord_t p0y;
  coord_t p1x;
  coord_t p1y;
  coord_t p2x;
  coord_t p2y;
  coord_t p3x;
  coord_t p3y;

  modport source (output valid, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, input ready);
  modport sink   (input valid, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, output ready);
endinterface

/* sv/quad_corner_clockwise_order.sv */
// quad corner reordering: four-stage pipeline from corners to wound corners
//
// usage
//   quad_in  carries one quad per item: corners a, b, c, d as signed q12.4 x/y
//   quad_out carries the same four corners reordered into a consistent winding
//   the block looks at the signs of twice the areas of triangles abc, acd, abd
//   and swaps at most one pair of corners; output bits are input bits unchanged
// timing
//   four register stages: an accepted item passes through stages 1, 2 and 3 and is
//   then offered on quad_out from the output register; one item per cycle is
//   sustained while quad_out does not stall; the four stages are edge vectors,
//   multipliers, area subtract, corner select into the output register
// reset
//   rst (synchronous, active high) empties the pipeline; only the valid bits are reset
// stalls
//   the whole pipeline advances together; when quad_out holds an unaccepted
//   item, every stage freezes and quad_in.ready drops, so nothing is lost
//   or repeated; bubbles move along with the items and are not closed up
module quad_corner_clockwise_order import qcco_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qcco_in_if.sink     quad_in,
  qcco_out_if.source  quad_out
);

  // pipeline advance: the output register is free or is being emptied
  logic adv;
  assign adv = !quad_out.valid || quad_out.ready;
  assign quad_in.ready = adv;

  // corners of the incoming item
  point_t in_pts [NUM_CORNERS];
  always_comb begin
    in_pts[0] = '{x: quad_in.ax, y: quad_in.ay};
    in_pts[1] = '{x: quad_in.bx, y: quad_in.by_coord};
    in_pts[2] = '{x: quad_in.cx, y: quad_in.cy};
    in_pts[3] = '{x: quad_in.dx, y: quad_in.dy};
  end

  // stage 1: edge vectors b-a, c-a, d-a
  logic   v1;
  point_t pts1 [NUM_CORNERS];
  diff_t  bdx, bdy, cdx, cdy, ddx, ddy;

  // stage 2: the six cross products
  logic   v2;
  point_t pts2 [NUM_CORNERS];
  prod_t  bx_cy, by_cx, cx_dy, cy_dx, bx_dy, by_dx;

  // stage 3: area signs
  logic       v3;
  point_t     pts3 [NUM_CORNERS];
  area_sign_t neg3;
  area_t      area_abc, area_acd, area_abd;

  // stage 4: selected order, held in the output register
  logic   out_valid;
  point_t out_pts [NUM_CORNERS];
  point_t sel_pts [NUM_CORNERS];

  // cross product of (q-p) and (r-p) equals the six-term doubled area
  assign area_abc = area_t'(bx_cy) - area_t'(by_cx);
  assign area_acd = area_t'(cx_dy) - area_t'(cy_dx);
  assign area_abd = area_t'(bx_dy) - area_t'(by_dx);

  // at most one swap, chosen by the sign pattern; zero counts as non-negative
  always_comb begin
    sel_pts = pts3;
    case ({neg3.abc, neg3.acd})
      2'b11: begin
        sel_pts = pts3;
      end
      2'b10: begin
        if (neg3.abd) begin
          sel_pts[2] = pts3[3];
          sel_pts[3] = pts3[2];
        end else begin
          sel_pts[0] = pts3[3];
          sel_pts[3] = pts3[0];
        end
      end
      2'b01: begin
        if (neg3.abd) begin
          sel_pts[1] = pts3[2];
          sel_pts[2] = pts3[1];
        end else begin
          sel_pts[0] = pts3[1];
          sel_pts[1] = pts3[0];
        end
      end
      2'b00: begin
        sel_pts[0] = pts3[2];
        sel_pts[2] = pts3[0];
      end
      default: begin
        sel_pts = pts3;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= quad_in.valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      pts1 <= in_pts;
      bdx  <= diff_t'(quad_in.bx)       - diff_t'(quad_in.ax);
      bdy  <= diff_t'(quad_in.by_coord) - diff_t'(quad_in.ay);
      cdx  <= diff_t'(quad_in.cx)       - diff_t'(quad_in.ax);
      cdy  <= diff_t'(quad_in.cy)       - diff_t'(quad_in.ay);
      ddx  <= diff_t'(quad_in.dx)       - diff_t'(quad_in.ax);
      ddy  <= diff_t'(quad_in.dy)       - diff_t'(quad_in.ay);

      pts2  <= pts1;
      bx_cy <= prod_t'(bdx) * prod_t'(cdy);
      by_cx <= prod_t'(bdy) * prod_t'(cdx);
      cx_dy <= prod_t'(cdx) * prod_t'(ddy);
      cy_dx <= prod_t'(cdy) * prod_t'(ddx);
      bx_dy <= prod_t'(bdx) * prod_t'(ddy);
      by_dx <= prod_t'(bdy) * prod_t'(ddx);

      pts3     <= pts2;
      neg3.abc <= area_abc[$bits(area_t)-1];
      neg3.acd <= area_acd[$bits(area_t)-1];
      neg3.abd <= area_abd[$bits(area_t)-1];

      out_pts <= sel_pts;
    end
  end

  assign quad_out.valid = out_valid;
  assign quad_out.p0x   = out_pts[0].x;
  assign quad_out.p0y   = out_pts[0].y;
  assign quad_out.p1x   = out_pts[1].x;
  assign quad_out.p1y   = out_pts[1].y;
  assign quad_out.p2x   = out_pts[2].x;
  assign quad_out.p2y   = out_pts[2].y;
  assign quad_out.p3x   = out_pts[3].x;
  assign quad_out.p3y   = out_pts[3].y;

`ifndef NO_ASSERTIONS
  // a frozen pipeline keeps every valid bit
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable({v1, v2, v3}) && quad_out.valid == $past(quad_out.valid)))
    else $error("pipeline valid bits moved during a stall");

  // both areas negative keeps corner a in front
  a_keep: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && neg3.abc && neg3.acd) |=>
      (quad_out.p0x == $past(pts3[0].x) && quad_out.p3y == $past(pts3[3].y)))
    else $error("kept order was altered");

  // both areas non-negative swaps a and c
  a_swap_ac: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && !neg3.abc && !neg3.acd) |=>
      (quad_out.p0y == $past(pts3[2].y) && quad_out.p2y == $past(pts3[0].y)))
    else $error("a/c swap missing");

  // corner b stays in its slot in the a/d and c/d swaps
  a_b_slot: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && neg3.abc && !neg3.acd) |=> (quad_out.p1x == $past(pts3[1].x)))
    else $error("corner b moved in an a/d or c/d swap");
`endif

endmodule

/* tb/sv/testbench.sv */
// testbench for the quad corner reordering block: stimulus, winding predictor and output checks
module testbench import qcco_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // long output hold-off, in cycles, used once in the random part
  localparam int HOLD_CYCLES = 300;
  // no idling on either side once this few quads are left to send
  localparam int CALM_TAIL = 100;

  // which pair of corners the winding fix swaps
  typedef enum int {
    WIND_KEEP,
    WIND_SWAP_CD,
    WIND_SWAP_AD,
    WIND_SWAP_BC,
    WIND_SWAP_AB,
    WIND_SWAP_AC
  } wind_fix_e;

  // corners a, b, c, d in slots 0..3
  typedef point_t [0:3] corners_t;

  typedef struct {
    corners_t pts;
    bit       drain_first;  // hold this quad back until the pipeline is empty
  } quad_req_t;

  logic clk;
  logic rst;

  qcco_in_if  quad_in ();
  qcco_out_if quad_out ();

  quad_corner_clockwise_order u_top (
    .clk      (clk),
    .rst      (rst),
    .quad_in  (quad_in),
    .quad_out (quad_out)
  );

  quad_req_t quads_pending[$];    // quads not yet accepted by the block
  corners_t  wound_expected[$];   // reordered quads still owed by the block

  int in_gap        = 0;
  int out_stall     = 0;
  bit out_hold      = 1'b0;
  int quads_sent    = 0;
  int quads_checked = 0;
  int mismatches    = 0;
  int directed_cnt  = 0;
  int wind_seen[6]  = '{default: 0};

  corners_t  wound_now;
  corners_t  got_quad;
  corners_t  want_quad;
  wind_fix_e fix_now;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // winding predictor
  // ---------------------------------------------------------------------------

  // twice the signed area of triangle pqr is negative (clockwise turn)
  // products of 16-bit values sum to well under 2^34, so a longint holds it exactly
  function automatic bit turns_clockwise(point_t p, point_t q, point_t r);
    longint twice_area;
    twice_area = longint'(p.x) * longint'(q.y) - longint'(p.y) * longint'(q.x)
               + longint'(q.x) * longint'(r.y) - longint'(q.y) * longint'(r.x)
               + longint'(r.x) * longint'(p.y) - longint'(r.y) * longint'(p.x);
    return twice_area < 0;
  endfunction

  // signs of abc, acd, abd from the corners as given pick at most one swap;
  // a zero area takes the non-negative branch
  function automatic corners_t wind_quad(corners_t q, output wind_fix_e fix);
    corners_t w;
    bit abc_cw;
    bit acd_cw;
    bit abd_cw;
    abc_cw = turns_clockwise(q[0], q[1], q[2]);
    acd_cw = turns_clockwise(q[0], q[2], q[3]);
    abd_cw = turns_clockwise(q[0], q[1], q[3]);
    if (abc_cw && acd_cw) fix = WIND_KEEP;
    else if (abc_cw) fix = abd_cw ? WIND_SWAP_CD : WIND_SWAP_AD;
    else if (acd_cw) fix = abd_cw ? WIND_SWAP_BC : WIND_SWAP_AB;
    else fix = WIND_SWAP_AC;
    w = q;
    case (fix)
      WIND_SWAP_CD: begin
        w[2] = q[3];
        w[3] = q[2];
      end
      WIND_SWAP_AD: begin
        w[0] = q[3];
        w[3] = q[0];
      end
      WIND_SWAP_BC: begin
        w[1] = q[2];
        w[2] = q[1];
      end
      WIND_SWAP_AB: begin
        w[0] = q[1];
        w[1] = q[0];
      end
      WIND_SWAP_AC: begin
        w[0] = q[2];
        w[2] = q[0];
      end
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idling comes in stretches, alternating with stretches of none, and stops
  // altogether near the end of the run
  function automatic bit idle_allowed();
    return quads_pending.size() >= CALM_TAIL && (quads_pending.size() / 60) % 3 != 0;
  endfunction

  task automatic add_quad(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy,
                          bit drain);
    quad_req_t r;
    r.pts[0] = '{x: coord_t'(ax), y: coord_t'(ay)};
    r.pts[1] = '{x: coord_t'(bx), y: coord_t'(by)};
    r.pts[2] = '{x: coord_t'(cx), y: coord_t'(cy)};
    r.pts[3] = '{x: coord_t'(dx), y: coord_t'(dy)};
    r.drain_first = drain;
    quads_pending.insert(quads_pending.size(), r);
  endtask

  // one coordinate, drawn according to the flavor of quad being built
  function automatic int pick_coord(int flavor);
    int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case (flavor)
      0: return int'($urandom_range(0, 65535)) - 32768;   // anything at all
      1: return int'($urandom_range(0, 6)) - 3;           // tiny: many zero areas
      default: return edges[$urandom_range(0, 6)];       // corner values of the range
    endcase
  endfunction

  task automatic fail_note(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the front pending quad, holds it until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quad_in.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      // an accepted quad turns into an expectation right away
      if (quad_in.valid && quad_in.ready) begin
        wound_now = wind_quad(quads_pending[0].pts, fix_now);
        wound_expected.insert(wound_expected.size(), wound_now);
        wind_seen[int'(fix_now)]++;
        void'(quads_pending.pop_front());
        quads_sent++;
      end
      // valid never drops while an item is offered and not yet taken
      if (!quad_in.valid || quad_in.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          quad_in.valid <= 1'b0;
        end else if (quads_pending.size() == 0) begin
          quad_in.valid <= 1'b0;
        end else if (quads_pending[0].drain_first && wound_expected.size() != 0) begin
          // sender pause: wait for every owed result first
          quad_in.valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 14);
          quad_in.valid <= 1'b0;
        end else begin
          quad_in.valid    <= 1'b1;
          quad_in.ax       <= quads_pending[0].pts[0].x;
          quad_in.ay       <= quads_pending[0].pts[0].y;
          quad_in.bx       <= quads_pending[0].pts[1].x;
          quad_in.by_coord <= quads_pending[0].pts[1].y;
          quad_in.cx       <= quads_pending[0].pts[2].x;
          quad_in.cy       <= quads_pending[0].pts[2].y;
          quad_in.dx       <= quads_pending[0].pts[3].x;
          quad_in.dy       <= quads_pending[0].pts[3].y;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted result against the oldest expectation,
  // and throttles ready with random stalls and the long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quad_out.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (quad_out.valid && quad_out.ready) begin
        got_quad[0] = '{x: quad_out.p0x, y: quad_out.p0y};
        got_quad[1] = '{x: quad_out.p1x, y: quad_out.p1y};
        got_quad[2] = '{x: quad_out.p2x, y: quad_out.p2y};
        got_quad[3] = '{x: quad_out.p3x, y: quad_out.p3y};
        if (wound_expected.size() == 0) begin
          fail_note($sformatf("result %0d arrived with nothing expected", quads_checked));
        end else begin
          want_quad = wound_expected.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got_quad[i].x !== want_quad[i].x)
              fail_note($sformatf("result %0d p%0dx expected %0d got %0d", quads_checked, i,
                                  want_quad[i].x, got_quad[i].x));
            if (got_quad[i].y !== want_quad[i].y)
              fail_note($sformatf("result %0d p%0dy expected %0d got %0d", quads_checked, i,
                                  want_quad[i].y, got_quad[i].y));
          end
        end
        quads_checked++;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        quad_out.ready <= 1'b0;
      end else if (out_hold) begin
        quad_out.ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
        out_stall <= $urandom_range(0, 14);
        quad_out.ready <= 1'b0;
      end else begin
        quad_out.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering: fills the pipeline
  // and must push back on quad_in.ready
  initial begin
    while (quads_sent < 250) @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int flavor;
    int x0;
    int y0;
    int rad;
    int sq[4][2];
    int start;
    int step;
    int k;

    rst = 1'b1;
    quad_in.valid = 1'b0;
    quad_in.ax = '0;
    quad_in.ay = '0;
    quad_in.bx = '0;
    quad_in.by_coord = '0;
    quad_in.cx = '0;
    quad_in.cy = '0;
    quad_in.dx = '0;
    quad_in.dy = '0;
    quad_out.ready = 1'b0;

    // directed: one quad for each winding branch
    add_quad(0, 0, 0, 16, 16, 16, 16, 0, 1'b0);     // clockwise square, kept
    add_quad(0, 0, 0, 16, 16, 0, 16, 16, 1'b0);     // abc cw, acd not, abd cw: c/d
    add_quad(0, 0, 0, 16, 16, 16, -16, 0, 1'b0);    // abc cw, acd not, abd not: a/d
    add_quad(0, 0, 16, 0, 16, 16, 0, -16, 1'b0);    // abc not, acd cw, abd cw: b/c
    add_quad(0, 0, 16, 0, 16, 16, 32, 16, 1'b0);    // abc not, acd cw, abd not: a/b
    add_quad(0, 0, 16, 0, 16, 16, 0, 16, 1'b0);     // counter-clockwise square: a/c
    // extremes of the coordinate range, largest possible areas
    add_quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 1'b0);
    add_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 1'b0);
    add_quad(32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
    add_quad(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 1'b0);
    // all corners alike
    add_quad(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_quad(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0);
    add_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    // degenerate: collinear corners and pairs that coincide
    add_quad(0, 0, 16, 16, 32, 32, 48, 48, 1'b0);
    add_quad(-32768, 0, 0, 0, 32767, 0, 100, 0, 1'b0);
    add_quad(5, 7, 5, 7, 20, -3, 20, -3, 1'b0);
    add_quad(0, 0, 0, 16, 0, 16, 16, 0, 1'b0);
    add_quad(0, 0, 16, 0, 16, 16, 16, 16, 1'b0);
    // alternating bit patterns
    add_quad(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA,
             16'hAAAA, 1'b0);
    directed_cnt = quads_pending.size();

    // random: half well-formed quads with a random winding and start corner,
    // the rest anything, tiny, or pinned to the range limits
    for (int i = 0; i < 600; i++) begin
      flavor = $urandom_range(0, 5);
      if (flavor >= 3) begin
        rad = $urandom_range(1, 8000);
        x0 = int'($urandom_range(0, 40000)) - 20000;
        y0 = int'($urandom_range(0, 40000)) - 20000;
        sq[0] = '{x0 - rad, y0 - rad};
        sq[1] = '{x0 + rad, y0 - rad};
        sq[2] = '{x0 + rad, y0 + rad};
        sq[3] = '{x0 - rad, y0 + rad};
        start = $urandom_range(0, 3);
        step = $urandom_range(0, 1) ? 1 : 3;
        // jitter each corner a little, and now and then trade two corners
        // so the quad becomes a bow-tie
        for (int j = 0; j < 4; j++) begin
          sq[j][0] += int'($urandom_range(0, 200)) - 100;
          sq[j][1] += int'($urandom_range(0, 200)) - 100;
        end
        k = start;
        if ($urandom_range(0, 3) == 0) step = 2;
        add_quad(sq[k][0], sq[k][1],
                 sq[(k + step) % 4][0], sq[(k + step) % 4][1],
                 sq[(k + 2 * step + (step == 2)) % 4][0],
                 sq[(k + 2 * step + (step == 2)) % 4][1],
                 sq[(k + 3 * step + (step == 2)) % 4][0],
                 sq[(k + 3 * step + (step == 2)) % 4][1],
                 i == 150 || i == 450);
      end else begin
        add_quad(pick_coord(flavor), pick_coord(flavor), pick_coord(flavor),
                 pick_coord(flavor), pick_coord(flavor), pick_coord(flavor),
                 pick_coord(flavor), pick_coord(flavor), i == 150 || i == 450);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all quads accepted, then all results back, then an idle stretch
    while (quads_pending.size() != 0 || quad_in.valid) @(posedge clk);
    while (wound_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d quads (%0d directed, rest random), %0d results checked,",
             quads_sent, directed_cnt, quads_checked);
    $display("with a %0d-cycle output hold; winding fixes seen: keep %0d, c/d %0d, a/d %0d,",
             HOLD_CYCLES, wind_seen[WIND_KEEP], wind_seen[WIND_SWAP_CD],
             wind_seen[WIND_SWAP_AD]);
    $display("b/c %0d, a/b %0d, a/c %0d",
             wind_seen[WIND_SWAP_BC], wind_seen[WIND_SWAP_AB], wind_seen[WIND_SWAP_AC]);
    if (mismatches == 0 && wound_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
